// ===== sv/tzr_pkg.sv =====
// ----------------------------------------------------------------------------
// tzr_pkg: shared types and codes of the touch zone router
// Holds the request and response item layouts, the zone entry layout, the
// command and touch kind codes, and the control group of the match unit.
// ----------------------------------------------------------------------------
package tzr_pkg;

	localparam int CoordW  = 16;
	localparam int RankW   = 8;
	localparam int TargetW = 4;
	localparam int SlotW   = 4;

	localparam logic [1:0] CMD_DISPATCH = 2'd0;
	localparam logic [1:0] CMD_WRITE    = 2'd1;
	localparam logic [1:0] CMD_CLEAR    = 2'd2;

	localparam logic [1:0] EV_DOWN = 2'd0;
	localparam logic [1:0] EV_UP   = 2'd2;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [SlotW-1:0]        slot;
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic [1:0]              event_req;
		logic [TargetW-1:0]      zone_index;
		logic                    zone_valid;
		logic signed [CoordW-1:0] zone_x0;
		logic signed [CoordW-1:0] zone_x1;
		logic signed [CoordW-1:0] zone_y0;
		logic signed [CoordW-1:0] zone_y1;
		logic [RankW-1:0]        zone_priority;
	} req_t;

	typedef struct packed {
		logic                     route_taken;
		logic [TargetW-1:0]       target_zone;
		logic [SlotW-1:0]         out_slot;
		logic signed [CoordW-1:0] out_x;
		logic signed [CoordW-1:0] out_y;
		logic [1:0]               out_event;
	} rsp_t;

	typedef struct packed {
		logic signed [CoordW-1:0] left;
		logic signed [CoordW-1:0] right;
		logic signed [CoordW-1:0] top;
		logic signed [CoordW-1:0] bottom;
		logic [RankW-1:0]         rank;
	} zone_t;

	typedef struct packed {
		logic clear;
		logic en;
	} scan_ctl_t;

endpackage

// ===== sv/tzr_stream_if.sv =====
// ----------------------------------------------------------------------------
// tzr_stream_if: valid/ready channel
// Carries one item per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface tzr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tzr_zone_table.sv =====
// ----------------------------------------------------------------------------
// tzr_zone_table: zone bounds memory with live bits
// One write port and one registered read port. Live bits clear at reset.
// ----------------------------------------------------------------------------
module tzr_zone_table #(
	parameter int ZONE_COUNT = 16,
	parameter int ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [ZW-1:0]   wr_addr,
	input  logic            wr_live,
	input  tzr_pkg::zone_t  wr_entry,
	input  logic            rd_en,
	input  logic [ZW-1:0]   rd_addr,
	output logic            rd_live,
	output tzr_pkg::zone_t  rd_entry
);
	import tzr_pkg::*;

	zone_t                 mem_q [ZONE_COUNT];
	logic [ZONE_COUNT-1:0] live_q;
	logic                  rd_live_q;
	zone_t                 rd_entry_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			rd_live_q <= 1'b0;
		end else begin
			if (wr_en) begin
				live_q[wr_addr] <= wr_live;
			end
			if (rd_en) begin
				rd_live_q <= live_q[rd_addr];
			end
		end
	end

	assign rd_live  = rd_live_q;
	assign rd_entry = rd_entry_q;
endmodule

// ===== sv/tzr_match_unit.sv =====
// ----------------------------------------------------------------------------
// tzr_match_unit: hit test and best-zone tracker
// Tests one zone entry per cycle against the touch point and keeps the
// highest-priority hit; a strictly greater rank is needed to replace it.
// ----------------------------------------------------------------------------
module tzr_match_unit #(
	parameter int ZONE_COUNT = 16,
	parameter int ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tzr_pkg::scan_ctl_t                ctl,
	input  logic                              entry_live,
	input  tzr_pkg::zone_t                    entry,
	input  logic [ZW-1:0]                     idx,
	input  logic signed [tzr_pkg::CoordW-1:0] px,
	input  logic signed [tzr_pkg::CoordW-1:0] py,
	output logic                              found,
	output logic [ZW-1:0]                     best_idx
);
	import tzr_pkg::*;

	logic             found_q;
	logic [ZW-1:0]    best_idx_q;
	logic [RankW-1:0] best_rank_q;
	logic             hit;
	logic             take;

	assign hit = entry_live && (px >= entry.left) && (px <= entry.right) &&
		(py >= entry.top) && (py <= entry.bottom);
	assign take = ctl.en && hit && (!found_q || (entry.rank > best_rank_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= idx;
			best_rank_q <= entry.rank;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;
endmodule

// ===== sv/touch_zone_router_top.sv =====
// ----------------------------------------------------------------------------
// touch_zone_router_top: routes touch items to rectangular zones
// Sequencer, claim store and result register around a zone table and a
// shared hit-test unit.
// ----------------------------------------------------------------------------
// The block takes request items on req and answers each with exactly one
// response item on rsp. A request either writes one zone entry, clears all
// slot claims, or dispatches a touch.
// Zone writes, claim clears, refused touches and touches on a claimed slot
// are settled in the cycle of acceptance; their response is then loaded
// into the output register from S_DONE once rsp is free.
// A Down touch on an unclaimed slot scans the zone table through the single
// read port, one entry per cycle, with the hit test in the cycle after the
// read; the sequencer then passes S_WAIT and S_CLAIM on to S_DONE.
// req.ready is high only while the sequencer is idle; one item is in work at
// a time. The response sits in an output register, so the next request is
// taken while an earlier response still waits. If the receiver stalls and a
// second response is finished, the sequencer holds it until rsp frees.
// Reset clears all live bits of the zone table, all claims and the response
// valid; zone bounds and priorities stay undefined until written.
// ----------------------------------------------------------------------------
module touch_zone_router_top #(
	parameter int ZONE_COUNT = 16,
	parameter int SLOT_COUNT = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	tzr_stream_if.sink   req,
	tzr_stream_if.source rsp
);
	import tzr_pkg::*;

	localparam int ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WAIT,
		S_CLAIM,
		S_DONE
	} state_t;

	state_t               state_q;
	req_t                 req_q;
	rsp_t                 res_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;
	logic [SLOT_COUNT-1:0] claim_flag_q;
	logic [TargetW-1:0]   claim_tgt_q [SLOT_COUNT];
	logic [ZW-1:0]        scan_idx_q;
	logic                 cmp_v_s1;
	logic [ZW-1:0]        cmp_idx_s1;

	req_t                 rd;
	logic                 accept;
	logic                 zone_ok;
	logic                 slot_ok;
	logic [SW-1:0]        slot_idx;
	logic                 claim_hit;
	logic                 scan_start;
	logic                 tab_wr_en;
	zone_t                tab_wr_entry;
	logic                 tab_rd_en;
	logic                 tab_rd_live;
	zone_t                tab_rd_entry;
	scan_ctl_t            scan_ctl;
	logic                 m_found;
	logic [ZW-1:0]        m_best;
	logic                 rsp_free;
	logic                 rsp_load;

	assign rd       = req.data;
	assign accept   = req.valid && req.ready;
	assign zone_ok  = 32'(rd.zone_index) < ZONE_COUNT;
	assign slot_ok  = 32'(rd.slot) < SLOT_COUNT;
	assign slot_idx = SW'(rd.slot);
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign rsp_load = (state_q == S_DONE) && rsp_free;

	// A touch on a claimed slot follows the claim whatever its kind; only a
	// Down touch on an unclaimed slot starts a table scan.
	assign claim_hit  = (rd.cmd == CMD_DISPATCH) && slot_ok && claim_flag_q[slot_idx];
	assign scan_start = (rd.cmd == CMD_DISPATCH) && slot_ok && !claim_flag_q[slot_idx] &&
		(rd.event_req == EV_DOWN);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Zone writes go straight into the table at acceptance.
	assign tab_wr_en    = accept && (rd.cmd == CMD_WRITE) && zone_ok;
	assign tab_wr_entry = '{left: rd.zone_x0, right: rd.zone_x1, top: rd.zone_y0,
		bottom: rd.zone_y1, rank: rd.zone_priority};
	assign tab_rd_en    = (state_q == S_SCAN);

	assign scan_ctl.clear = accept;
	assign scan_ctl.en    = cmp_v_s1;

	tzr_zone_table #(
		.ZONE_COUNT(ZONE_COUNT)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (tab_wr_en),
		.wr_addr  (ZW'(rd.zone_index)),
		.wr_live  (rd.zone_valid),
		.wr_entry (tab_wr_entry),
		.rd_en    (tab_rd_en),
		.rd_addr  (scan_idx_q),
		.rd_live  (tab_rd_live),
		.rd_entry (tab_rd_entry)
	);

	tzr_match_unit #(
		.ZONE_COUNT(ZONE_COUNT)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.entry_live (tab_rd_live),
		.entry      (tab_rd_entry),
		.idx        (cmp_idx_s1),
		.px         (req_q.x),
		.py         (req_q.y),
		.found      (m_found),
		.best_idx   (m_best)
	);

	// The read data of the table is registered and lands in the cycle after the
	// address, so the hit test runs on a one-stage delayed copy of the scan index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_v_s1 <= 1'b0;
		end else begin
			cmp_v_s1 <= tab_rd_en;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rsp_valid_q  <= 1'b0;
			claim_flag_q <= '0;
			for (int k = 0; k < SLOT_COUNT; k++) begin
				claim_tgt_q[k] <= '0;
			end
			scan_idx_q   <= '0;
			req_q        <= '0;
			res_q        <= '0;
			rsp_q        <= '0;
		end else begin
			// A new response may replace one that leaves in the same cycle.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q      <= rd;
						scan_idx_q <= '0;
						if (scan_start) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
						if (claim_hit) begin
							res_q <= '{route_taken: 1'b1,
								target_zone: claim_tgt_q[slot_idx],
								out_slot: rd.slot, out_x: rd.x, out_y: rd.y,
								out_event: rd.event_req};
						end else begin
							res_q <= '0;
						end
						unique case (rd.cmd)
							CMD_WRITE: begin
								// Removing a zone drops every claim on it.
								if (zone_ok && !rd.zone_valid) begin
									for (int k = 0; k < SLOT_COUNT; k++) begin
										if (claim_tgt_q[k] == rd.zone_index) begin
											claim_flag_q[k] <= 1'b0;
										end
									end
								end
							end
							CMD_CLEAR: begin
								claim_flag_q <= '0;
							end
							CMD_DISPATCH: begin
								if (claim_hit && (rd.event_req == EV_UP)) begin
									claim_flag_q[slot_idx] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_idx_q == ZW'(ZONE_COUNT - 1)) begin
						state_q <= S_WAIT;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				S_WAIT: begin
					state_q <= S_CLAIM;
				end
				S_CLAIM: begin
					if (m_found) begin
						claim_flag_q[SW'(req_q.slot)] <= 1'b1;
						claim_tgt_q[SW'(req_q.slot)]  <= TargetW'(m_best);
						res_q <= '{route_taken: 1'b1, target_zone: TargetW'(m_best),
							out_slot: req_q.slot, out_x: req_q.x, out_y: req_q.y,
							out_event: req_q.event_req};
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== sv/tzr_checker.sv =====
// ----------------------------------------------------------------------------
// tzr_checker: port-level checks of the touch zone router
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module tzr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input tzr_pkg::rsp_t rsp_data
);
	import tzr_pkg::*;

	// A waiting response must not be withdrawn.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// One item at a time: the block is busy right after taking a request.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in work");

	// An unrouted response carries nothing but zeros.
	a_unrouted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.route_taken |->
		(rsp_data.target_zone == '0) && (rsp_data.out_slot == '0) &&
		(rsp_data.out_x == '0) && (rsp_data.out_y == '0) &&
		(rsp_data.out_event == '0))
		else $error("unrouted response with nonzero fields");
endmodule

bind touch_zone_router_top tzr_checker u_tzr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// ===== verif/touch_zone_router_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_zone_router_top_test: self-checking bench for the touch zone router
// Loads the zone table, runs directed touches through priority, tie, claim,
// removal and refusal cases, then random gesture traffic under three idling
// patterns. Each response item is checked against a behavioral predictor.
// ----------------------------------------------------------------------------
module touch_zone_router_top_test;
	import tzr_pkg::*;

	localparam int ZONES = 16;
	localparam int SLOTS = 10;

	// Codes that the package leaves unnamed.
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam logic [1:0] EV_MOVE = 2'd1;
	localparam logic [1:0] EV_ODD  = 2'd3;

	localparam int RANDOM_PER_PHASE = 150;
	localparam int REPORT_LIMIT     = 10;

	logic clk;
	logic arst_n;

	tzr_stream_if #(.payload_t(req_t)) req_ch ();
	tzr_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	touch_zone_router_top #(
		.ZONE_COUNT(ZONES),
		.SLOT_COUNT(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Shadow copy of the zone table and of the per-slot claims. It is updated
	// at the moment an item is accepted, so it always reflects the block's
	// state as seen by the next request item.
	logic               zone_live [ZONES];
	zone_t              zone_tab [ZONES];
	logic               slot_claimed [SLOTS];
	logic [TargetW-1:0] slot_zone [SLOTS];

	// Responses still owed by the block, oldest first.
	rsp_t pending_routes [$];

	int send_idle_pct = 27;
	int recv_idle_pct = 86;

	int mismatches     = 0;
	int results_seen   = 0;
	int routed_seen    = 0;
	int items_accepted = 0;
	int useful_items   = 0;
	int zone_writes    = 0;

	// ------------------------------------------------------------------------
	// Clock and run limit
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The slowest legal run is well under a millisecond; this only catches a
	// hung handshake.
	initial begin
		#(5_000_000);
		$display("touch_zone_router_top_test: errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic void clear_router_state();
		for (int z = 0; z < ZONES; z++) begin
			zone_live[z] = 1'b0;
			zone_tab[z]  = '0;
		end
		for (int s = 0; s < SLOTS; s++) begin
			slot_claimed[s] = 1'b0;
			slot_zone[s]    = '0;
		end
	endfunction

	// Bounds are inclusive on all four sides. A box whose low bound lies above
	// its high bound holds nothing, which falls out of the compares.
	function automatic logic zone_hit(input int z, input logic signed [CoordW-1:0] px,
			input logic signed [CoordW-1:0] py);
		return px >= zone_tab[z].left && px <= zone_tab[z].right &&
			py >= zone_tab[z].top && py <= zone_tab[z].bottom;
	endfunction

	// Applies one request item to the shadow state and returns the response
	// item that the block owes for it.
	function automatic rsp_t route_touch(input req_t r);
		rsp_t res;
		int   best;
		logic found;
		res   = '0;
		best  = 0;
		found = 1'b0;
		case (r.cmd)
			CMD_WRITE: begin
				zone_live[r.zone_index] = r.zone_valid;
				zone_tab[r.zone_index]  = '{left: r.zone_x0, right: r.zone_x1,
					top: r.zone_y0, bottom: r.zone_y1, rank: r.zone_priority};
				// Removing a zone drops every claim on it; a live rewrite keeps them.
				if (!r.zone_valid) begin
					for (int s = 0; s < SLOTS; s++)
						if (slot_claimed[s] && slot_zone[s] == r.zone_index)
							slot_claimed[s] = 1'b0;
				end
			end
			CMD_CLEAR: begin
				for (int s = 0; s < SLOTS; s++)
					slot_claimed[s] = 1'b0;
			end
			CMD_DISPATCH: begin
				if (r.slot < SLOTS) begin
					if (slot_claimed[r.slot]) begin
						// Any touch kind follows the claim; only Up releases it.
						found = 1'b1;
						best  = int'(slot_zone[r.slot]);
						if (r.event_req == EV_UP)
							slot_claimed[r.slot] = 1'b0;
					end else if (r.event_req == EV_DOWN) begin
						// Strictly greater rank replaces, so the lowest index wins a tie.
						for (int z = 0; z < ZONES; z++)
							if (zone_live[z] && zone_hit(z, r.x, r.y) &&
									(!found || zone_tab[z].rank > zone_tab[best].rank)) begin
								best  = z;
								found = 1'b1;
							end
						if (found) begin
							slot_claimed[r.slot] = 1'b1;
							slot_zone[r.slot]    = best[TargetW-1:0];
						end
					end
					if (found)
						res = '{route_taken: 1'b1, target_zone: best[TargetW-1:0],
							out_slot: r.slot, out_x: r.x, out_y: r.y, out_event: r.event_req};
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Item builders
	// ------------------------------------------------------------------------
	// Every field random; callers overwrite the fields that matter, so the
	// don't-care fields still see all their bits toggle.
	function automatic req_t noise_item();
		req_t r;
		r.cmd           = 2'($urandom_range(3));
		r.slot          = SlotW'($urandom_range(15));
		r.x             = CoordW'($urandom);
		r.y             = CoordW'($urandom);
		r.event_req     = 2'($urandom_range(3));
		r.zone_index    = TargetW'($urandom_range(15));
		r.zone_valid    = 1'($urandom_range(1));
		r.zone_x0       = CoordW'($urandom);
		r.zone_x1       = CoordW'($urandom);
		r.zone_y0       = CoordW'($urandom);
		r.zone_y1       = CoordW'($urandom);
		r.zone_priority = RankW'($urandom_range(255));
		return r;
	endfunction

	function automatic req_t touch_item(input logic [SlotW-1:0] s, input logic [1:0] ev,
			input logic signed [CoordW-1:0] px, input logic signed [CoordW-1:0] py);
		req_t r;
		r           = noise_item();
		r.cmd       = CMD_DISPATCH;
		r.slot      = s;
		r.event_req = ev;
		r.x         = px;
		r.y         = py;
		return r;
	endfunction

	function automatic req_t zone_item(input logic [TargetW-1:0] idx, input logic live,
			input logic signed [CoordW-1:0] x0, input logic signed [CoordW-1:0] x1,
			input logic signed [CoordW-1:0] y0, input logic signed [CoordW-1:0] y1,
			input logic [RankW-1:0] rank);
		req_t r;
		r               = noise_item();
		r.cmd           = CMD_WRITE;
		r.zone_index    = idx;
		r.zone_valid    = live;
		r.zone_x0       = x0;
		r.zone_x1       = x1;
		r.zone_y0       = y0;
		r.zone_y1       = y1;
		r.zone_priority = rank;
		return r;
	endfunction

	function automatic req_t cmd_item(input logic [1:0] code);
		req_t r;
		r     = noise_item();
		r.cmd = code;
		return r;
	endfunction

	// Mostly a point inside some live, non-empty zone, so that Down touches
	// claim something; otherwise a point near the origin or anywhere at all.
	function automatic void pick_point(output logic signed [CoordW-1:0] px,
			output logic signed [CoordW-1:0] py);
		int live_list [$];
		int z;
		for (int i = 0; i < ZONES; i++)
			if (zone_live[i] && zone_tab[i].left <= zone_tab[i].right &&
					zone_tab[i].top <= zone_tab[i].bottom)
				live_list.push_back(i);
		if (live_list.size() == 0 || $urandom_range(9) < 2) begin
			if ($urandom_range(1)) begin
				px = CoordW'($urandom);
				py = CoordW'($urandom);
			end else begin
				px = CoordW'(int'($urandom_range(4000)) - 2000);
				py = CoordW'(int'($urandom_range(4000)) - 2000);
			end
		end else begin
			z  = live_list[$urandom_range(live_list.size() - 1)];
			px = CoordW'(int'(zone_tab[z].left) +
				int'($urandom_range(int'(zone_tab[z].right) - int'(zone_tab[z].left))));
			py = CoordW'(int'(zone_tab[z].top) +
				int'($urandom_range(int'(zone_tab[z].bottom) - int'(zone_tab[z].top))));
		end
	endfunction

	// Overlapping boxes near the origin with small ranks give frequent ties;
	// a few writes carry fully random or full-screen bounds.
	function automatic req_t random_zone_write();
		req_t r;
		int   cx;
		int   cy;
		int   sel;
		r            = noise_item();
		r.cmd        = CMD_WRITE;
		r.zone_valid = ($urandom_range(9) < 8);
		sel          = $urandom_range(19);
		if (sel < 15) begin
			cx        = int'($urandom_range(4000)) - 2000;
			cy        = int'($urandom_range(4000)) - 2000;
			r.zone_x0 = CoordW'(cx);
			r.zone_x1 = CoordW'(cx + int'($urandom_range(1500)));
			r.zone_y0 = CoordW'(cy);
			r.zone_y1 = CoordW'(cy + int'($urandom_range(1500)));
			if (sel == 0) begin
				r.zone_x0 = r.zone_x1 + 16'sd1;
			end
		end else if (sel == 19) begin
			r.zone_x0 = 16'sh8000;
			r.zone_x1 = 16'sh7FFF;
			r.zone_y0 = 16'sh8000;
			r.zone_y1 = 16'sh7FFF;
		end
		r.zone_priority = RankW'($urandom_range(1) ? $urandom_range(3) : $urandom_range(255));
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Request side: one item per call. Inputs change on the falling edge; the
	// handshake is sampled on the rising edge. valid stays high on return, so
	// a following call can present the next item without a gap.
	// ------------------------------------------------------------------------
	task automatic send_item(input req_t item);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= item;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pending_routes.push_back(route_touch(item));
		items_accepted++;
		if (item.cmd == CMD_WRITE)
			zone_writes++;
		if (item.cmd != CMD_NOP && !(item.cmd == CMD_DISPATCH && item.slot >= SLOTS))
			useful_items++;
	endtask

	// Drops valid and waits until every owed response item has come back.
	task automatic drain_routes();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_routes.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Response side: random back-pressure and the checker.
	// ------------------------------------------------------------------------
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic void note_failure(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = rsp_ch.data;
			results_seen++;
			if (pending_routes.size() == 0) begin
				note_failure($sformatf("response item %0d arrived with nothing owed: %p",
					results_seen, got));
			end else begin
				want = pending_routes.pop_front();
				if (want.route_taken)
					routed_seen++;
				if (got.route_taken !== want.route_taken ||
						got.target_zone !== want.target_zone ||
						got.out_slot !== want.out_slot || got.out_x !== want.out_x ||
						got.out_y !== want.out_y || got.out_event !== want.out_event)
					note_failure($sformatf({"response item %0d mismatch:",
						" expected taken=%0d zone=%0d slot=%0d x=%0d y=%0d ev=%0d,",
						" got taken=%0d zone=%0d slot=%0d x=%0d y=%0d ev=%0d"},
						results_seen, want.route_taken, want.target_zone, want.out_slot,
						want.out_x, want.out_y, want.out_event, got.route_taken,
						got.target_zone, got.out_slot, got.out_x, got.out_y, got.out_event));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Every table entry is written before the first Down scan, so no scan ever
	// reads bounds that were never written. Zones 0-2 overlap at different
	// ranks with a tie between 1 and 2, zone 3 covers the whole plane at the
	// lowest rank, zone 4 is an empty box at top rank and zone 5 a single
	// point at top rank. The rest are dead entries with arbitrary contents.
	task automatic test_zone_table_load();
		req_t r;
		send_item(zone_item(4'd0, 1'b1, 16'sd0, 16'sd160, 16'sd0, 16'sd160, 8'd10));
		send_item(zone_item(4'd1, 1'b1, 16'sd80, 16'sd240, 16'sd80, 16'sd240, 8'd20));
		send_item(zone_item(4'd2, 1'b1, 16'sd80, 16'sd240, 16'sd80, 16'sd240, 8'd20));
		send_item(zone_item(4'd3, 1'b1, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 8'd0));
		send_item(zone_item(4'd4, 1'b1, 16'sd500, 16'sd400, 16'sd0, 16'sd100, 8'd255));
		send_item(zone_item(4'd5, 1'b1, 16'sd1000, 16'sd1000, 16'sd1000, 16'sd1000, 8'd255));
		for (int z = 6; z < ZONES - 1; z++) begin
			r            = noise_item();
			r.cmd        = CMD_WRITE;
			r.zone_index = TargetW'(z);
			r.zone_valid = 1'b0;
			send_item(r);
		end
		send_item(zone_item(4'd15, 1'b0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 8'd255));
		drain_routes();
	endtask

	// Highest rank wins, the lower index wins the tie, an empty box never
	// matches, edges and extreme corners count as inside.
	task automatic test_priority_and_ties();
		send_item(touch_item(4'd0, EV_DOWN, 16'sd100, 16'sd100));
		send_item(touch_item(4'd1, EV_DOWN, 16'sd450, 16'sd50));
		send_item(touch_item(4'd2, EV_DOWN, 16'sd1000, 16'sd1000));
		send_item(touch_item(4'd3, EV_DOWN, 16'sd240, 16'sd240));
		send_item(touch_item(4'd4, EV_DOWN, 16'sh7FFF, 16'sh7FFF));
		send_item(touch_item(4'd6, EV_DOWN, 16'sh8000, 16'sh8000));
		drain_routes();
	endtask

	// A claim follows every touch kind on its slot, even Down and the unused
	// code 3, until an Up releases it. Without a claim only Down is routed.
	task automatic test_claim_lifetime();
		send_item(touch_item(4'd0, EV_MOVE, 16'sh8000, 16'sh7FFF));
		send_item(touch_item(4'd0, EV_DOWN, 16'sd5, 16'sd5));
		send_item(touch_item(4'd0, EV_ODD, 16'sd7, 16'sd7));
		send_item(touch_item(4'd0, EV_UP, 16'sd7, 16'sd7));
		send_item(touch_item(4'd0, EV_MOVE, 16'sd100, 16'sd100));
		send_item(touch_item(4'd7, EV_ODD, 16'sd100, 16'sd100));
		drain_routes();
	endtask

	// Slots at or above the slot count are refused whatever the touch.
	task automatic test_refused_slots();
		send_item(touch_item(4'd10, EV_DOWN, 16'sd100, 16'sd100));
		send_item(touch_item(4'd15, EV_DOWN, 16'sd100, 16'sd100));
		drain_routes();
	endtask

	// A live rewrite keeps the claims on a zone and changes later scans; a
	// removal drops the claims on it.
	task automatic test_zone_rewrite_and_removal();
		send_item(zone_item(4'd1, 1'b1, 16'sd80, 16'sd240, 16'sd80, 16'sd240, 8'd5));
		send_item(touch_item(4'd3, EV_MOVE, 16'sd10, 16'sd10));
		send_item(touch_item(4'd5, EV_DOWN, 16'sd100, 16'sd100));
		send_item(zone_item(4'd5, 1'b0, 16'sd1000, 16'sd1000, 16'sd1000, 16'sd1000, 8'd255));
		send_item(touch_item(4'd2, EV_MOVE, 16'sd1000, 16'sd1000));
		drain_routes();
	endtask

	// The unused command does nothing; a claim clear drops every claim.
	task automatic test_claim_clear();
		send_item(cmd_item(CMD_NOP));
		send_item(cmd_item(CMD_CLEAR));
		send_item(touch_item(4'd1, EV_MOVE, 16'sd450, 16'sd50));
		drain_routes();
	endtask

	// One finger: Down somewhere likely to hit, a few Moves, usually an Up.
	task automatic run_gesture();
		logic [SlotW-1:0]         s;
		logic signed [CoordW-1:0] px;
		logic signed [CoordW-1:0] py;
		int                       moves;
		s = SlotW'($urandom_range(SLOTS - 1));
		pick_point(px, py);
		send_item(touch_item(s, EV_DOWN, px, py));
		moves = $urandom_range(4);
		repeat (moves) begin
			px = CoordW'(int'(px) + int'($urandom_range(64)) - 32);
			py = CoordW'(int'(py) + int'($urandom_range(64)) - 32);
			send_item(touch_item(s, ($urandom_range(19) == 0) ? EV_ODD : EV_MOVE, px, py));
		end
		if ($urandom_range(9) < 8)
			send_item(touch_item(s, EV_UP, px, py));
	endtask

	// Gestures make up most of the traffic; the rest is table churn, clears,
	// stray touches, refused slots and the unused command.
	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		req_t r;
		int   goal;
		int   pick;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		goal          = useful_items + RANDOM_PER_PHASE;
		while (useful_items < goal) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				run_gesture();
			end else if (pick < 70) begin
				send_item(random_zone_write());
			end else if (pick < 74) begin
				send_item(cmd_item(CMD_CLEAR));
			end else if (pick < 78) begin
				send_item(cmd_item(CMD_NOP));
			end else if (pick < 93) begin
				r      = noise_item();
				r.cmd  = CMD_DISPATCH;
				r.slot = SlotW'($urandom_range(SLOTS - 1));
				if ($urandom_range(1))
					pick_point(r.x, r.y);
				send_item(r);
			end else begin
				r      = noise_item();
				r.cmd  = CMD_DISPATCH;
				r.slot = SlotW'($urandom_range(15, SLOTS));
				send_item(r);
			end
		end
		drain_routes();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		clear_router_state();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_zone_table_load();
		test_priority_and_ties();
		test_claim_lifetime();
		test_refused_slots();
		test_zone_rewrite_and_removal();
		test_claim_clear();

		// Slow receiver first, then slow sender, then both at full rate.
		test_random_traffic(27, 86);
		test_random_traffic(86, 27);
		test_random_traffic(0, 0);

		// Long enough for a full table scan plus the output register, so a
		// stray extra response would still be caught by the checker.
		repeat (ZONES + 8) @(posedge clk);

		$display("Sent %0d request items (%0d zone writes); checked %0d responses, %0d routed.",
			items_accepted, zone_writes, results_seen, routed_seen);
		$display("Mismatching or unexpected responses: %0d.", mismatches);
		if (mismatches == 0) begin
			$display("touch_zone_router_top_test: clean");
		end else begin
			$display("touch_zone_router_top_test: errors");
		end
		$finish;
	end

endmodule
